// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== hdl/pcs_pkg.sv =====
// Package of the precharge and contactor sequencer: types, codes and constants.
`default_nettype none

package pcs_pkg;

    // Sequence phases
    typedef enum logic [2:0] {
        PH_BOOTED  = 3'd0,
        PH_CONV    = 3'd1,
        PH_CHARGE  = 3'd2,
        PH_CLOSING = 3'd3,
        PH_CONFIRM = 3'd4,
        PH_DONE    = 3'd5,
        PH_FAILED  = 3'd6
    } phase_t;

    // Reported sequence status codes
    localparam logic [1:0] STATUS_BOOTED      = 2'd0;
    localparam logic [1:0] STATUS_PRECHARGING = 2'd1;
    localparam logic [1:0] STATUS_PRECHARGED  = 2'd2;
    localparam logic [1:0] STATUS_FAILED      = 2'd3;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_BUS_VOLTAGE     = 2'd0,
        CFG_DONE_RISE_RATE      = 2'd1,
        CFG_EARLY_VOLTAGE_LIMIT = 2'd2,
        CFG_TICK_LIMIT          = 2'd3
    } cfg_index_t;

    localparam int CfgDataWidth = 20;
    localparam int RateWidth    = 21;

    // Reset values
    localparam logic [15:0] MIN_BUS_VOLTAGE_RST     = 16'd1800;
    localparam logic [19:0] DONE_RISE_RATE_RST      = 20'd100;
    localparam logic [15:0] EARLY_VOLTAGE_LIMIT_RST = 16'd2000;
    localparam logic [5:0]  TICK_LIMIT_RST          = 6'd50;
    // Rise rate assumed at the start of charging: 100 V/s
    localparam logic signed [RateWidth-1:0] RATE_START = 21'sd10000;

    // One tick item
    typedef struct packed {
        logic [15:0] bus_voltage;
        logic [11:0] sense_raw;
        logic        stop_active;
    } tick_t;

    // One result item
    typedef struct packed {
        logic [1:0] sequence_status;
        logic       precharge_relay;
        logic       main_contactor;
        logic       gate_enable;
        logic       motor_locked;
    } result_t;

    // Configuration register set
    typedef struct packed {
        logic [15:0] min_bus_voltage;
        logic [19:0] done_rise_rate;
        logic [15:0] early_voltage_limit;
        logic [5:0]  tick_limit;
    } cfg_t;

    // Sequencer state carried from tick to tick
    typedef struct packed {
        phase_t                       phase;
        logic [5:0]                   tick_count;
        logic [15:0]                  previous_voltage;
        logic signed [RateWidth-1:0]  rise_rate;
    } seq_state_t;

endpackage

`default_nettype wire

// ===== hdl/pcs_step.sv =====
// Next-state and result logic for one tick of the sequencer.
`default_nettype none

module pcs_step (
    input  wire pcs_pkg::seq_state_t state,
    input  wire pcs_pkg::cfg_t       cfg,
    input  wire pcs_pkg::tick_t      tick,
    output pcs_pkg::seq_state_t      state_next,
    output pcs_pkg::result_t         result_next
);

    logic signed [pcs_pkg::RateWidth-1:0] diff;
    logic signed [pcs_pkg::RateWidth-1:0] delta;

    // Rise rate over one tick: (this sample - previous sample) * 10, always in range
    assign diff  = $signed({5'd0, tick.bus_voltage}) - $signed({5'd0, state.previous_voltage});
    assign delta = (diff <<< 3) + (diff <<< 1);

    // Phase walk for this tick
    always_comb
    begin
        pcs_pkg::phase_t                      ph;
        pcs_pkg::phase_t                      nph;
        logic [5:0]                           tc;
        logic [15:0]                          pv;
        logic signed [pcs_pkg::RateWidth-1:0] rr;
        logic                                 entered;
        logic                                 busy;

        ph      = state.phase;
        tc      = state.tick_count;
        pv      = state.previous_voltage;
        rr      = state.rise_rate;
        entered = 1'b0;
        busy    = 1'b0;

        // leave booted once the stop is released
        if (ph == pcs_pkg::PH_BOOTED && !tick.stop_active)
        begin
            ph = pcs_pkg::PH_CONV;
            tc = 6'd0;
        end

        // converter wait, may end in the same tick
        if (ph == pcs_pkg::PH_CONV)
        begin
            if (tick.sense_raw == 12'd0 && tc < cfg.tick_limit
                && state.phase == pcs_pkg::PH_CONV)
            begin
                tc = 6'(tc + 6'd1);
            end
            if (tick.sense_raw != 12'd0 || tc >= cfg.tick_limit)
            begin
                if (tick.bus_voltage > cfg.early_voltage_limit)
                begin
                    ph = pcs_pkg::PH_FAILED;
                end
                else
                begin
                    ph      = pcs_pkg::PH_CHARGE;
                    entered = 1'b1;
                    tc      = 6'd0;
                    pv      = tick.bus_voltage;
                    rr      = pcs_pkg::RATE_START;
                end
            end
        end

        nph = ph;
        unique case (ph) inside
            pcs_pkg::PH_CHARGE:
            begin
                if (!entered)
                begin
                    rr = delta;
                    pv = tick.bus_voltage;
                    tc = 6'(tc + 6'd1);
                end
                // rate is never above 655350, so its low 20 bits carry it
                busy = (tick.bus_voltage < cfg.min_bus_voltage)
                    || (!rr[pcs_pkg::RateWidth-1]
                        && (rr[pcs_pkg::RateWidth-2:0] > cfg.done_rise_rate));
                if (tc >= cfg.tick_limit)
                    nph = pcs_pkg::PH_FAILED;
                else if (!busy)
                    nph = pcs_pkg::PH_CLOSING;
            end
            pcs_pkg::PH_CLOSING: nph = pcs_pkg::PH_CONFIRM;
            pcs_pkg::PH_CONFIRM:
                nph = (tick.bus_voltage < pv) ? pcs_pkg::PH_FAILED : pcs_pkg::PH_DONE;
            pcs_pkg::PH_BOOTED, pcs_pkg::PH_CONV, pcs_pkg::PH_DONE, pcs_pkg::PH_FAILED:
                nph = ph;
            default: nph = pcs_pkg::PH_FAILED;
        endcase

        state_next.phase            = nph;
        state_next.tick_count       = tc;
        state_next.previous_voltage = pv;
        state_next.rise_rate        = rr;
    end

    // Output decode from the phase after the tick
    always_comb
    begin
        unique case (state_next.phase) inside
            pcs_pkg::PH_BOOTED: result_next.sequence_status = pcs_pkg::STATUS_BOOTED;
            pcs_pkg::PH_DONE:   result_next.sequence_status = pcs_pkg::STATUS_PRECHARGED;
            pcs_pkg::PH_FAILED: result_next.sequence_status = pcs_pkg::STATUS_FAILED;
            pcs_pkg::PH_CONV, pcs_pkg::PH_CHARGE, pcs_pkg::PH_CLOSING, pcs_pkg::PH_CONFIRM:
                result_next.sequence_status = pcs_pkg::STATUS_PRECHARGING;
            default: result_next.sequence_status = pcs_pkg::STATUS_FAILED;
        endcase
        result_next.precharge_relay = (state_next.phase == pcs_pkg::PH_CHARGE)
                                   || (state_next.phase == pcs_pkg::PH_CLOSING);
        result_next.main_contactor  = (state_next.phase == pcs_pkg::PH_CLOSING)
                                   || (state_next.phase == pcs_pkg::PH_CONFIRM)
                                   || (state_next.phase == pcs_pkg::PH_DONE);
        result_next.gate_enable     = (state_next.phase == pcs_pkg::PH_DONE);
        result_next.motor_locked    = (state_next.phase != pcs_pkg::PH_BOOTED)
                                   && (state_next.phase != pcs_pkg::PH_DONE);
    end

endmodule

`default_nettype wire

// ===== hdl/precharge_contactor_sequencer.sv =====
// Top level of the precharge relay and main contactor start-up sequencer.
//
// Channels: tick (valid/ready) brings one 100 ms sample: bus voltage, raw
// sense code and stop flag. result (valid/ready) returns one item per tick
// with the status and relay, contactor, gate and motor-lock drives after it.
// cfg (valid/ready, always ready) writes one of four threshold registers;
// write only while no tick is in flight.
// A tick is held in the tick register and its result in the result register.
// Throughput: one tick per cycle while result drains; the only loop is the
// state update, which is one short pass of compare and add logic between the
// tick register and the result register.
// Stall: the tick register keeps taking items as long as the result register
// is empty or being drained; with result held, one tick waits in the tick
// register and tick_ready drops.
// Reset: the sequence returns to booted, tick count and previous voltage to
// zero, rise rate to 100 V/s and the registers to their defaults; both
// pipeline valids clear.
`default_nettype none
`include "assert_macros.svh"

module precharge_contactor_sequencer (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  tick_valid,
    output logic                                 tick_ready,
    input  wire pcs_pkg::tick_t                  tick,
    output logic                                 result_valid,
    input  wire                                  result_ready,
    output pcs_pkg::result_t                     result,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire pcs_pkg::cfg_index_t             cfg_index,
    input  wire [pcs_pkg::CfgDataWidth-1:0]      cfg_data
);

    pcs_pkg::tick_t      tick_reg;
    logic                tick_valid_reg;
    pcs_pkg::seq_state_t state_reg;
    pcs_pkg::seq_state_t state_next;
    pcs_pkg::cfg_t       cfg_reg;
    pcs_pkg::result_t    result_reg;
    pcs_pkg::result_t    result_next;
    logic                result_valid_reg;
    logic                advance;

    // Item moves from the tick register into the result register
    assign advance    = tick_valid_reg && (!result_valid_reg || result_ready);
    assign tick_ready = !tick_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_bus_voltage     <= pcs_pkg::MIN_BUS_VOLTAGE_RST;
            cfg_reg.done_rise_rate      <= pcs_pkg::DONE_RISE_RATE_RST;
            cfg_reg.early_voltage_limit <= pcs_pkg::EARLY_VOLTAGE_LIMIT_RST;
            cfg_reg.tick_limit          <= pcs_pkg::TICK_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pcs_pkg::CFG_MIN_BUS_VOLTAGE:     cfg_reg.min_bus_voltage     <= cfg_data[15:0];
                pcs_pkg::CFG_DONE_RISE_RATE:      cfg_reg.done_rise_rate      <= cfg_data;
                pcs_pkg::CFG_EARLY_VOLTAGE_LIMIT: cfg_reg.early_voltage_limit <= cfg_data[15:0];
                pcs_pkg::CFG_TICK_LIMIT:          cfg_reg.tick_limit          <= cfg_data[5:0];
                default:                          cfg_reg.tick_limit          <= cfg_reg.tick_limit;
            endcase
        end
    end

    // Tick input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (tick_ready)
            tick_valid_reg <= tick_valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
            tick_reg <= tick;
    end

    // Per-tick sequencing logic
    pcs_step u_step (
        .state       (state_reg),
        .cfg         (cfg_reg),
        .tick        (tick_reg),
        .state_next  (state_next),
        .result_next (result_next)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase            <= pcs_pkg::PH_BOOTED;
            state_reg.tick_count       <= 6'd0;
            state_reg.previous_voltage <= 16'd0;
            state_reg.rise_rate        <= pcs_pkg::RATE_START;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    `ASSERT_CLK(a_failed_holds, clk, rst_n,
        state_reg.phase == pcs_pkg::PH_FAILED |=> state_reg.phase == pcs_pkg::PH_FAILED,
        "failed phase left before reset")
    `ASSERT_CLK(a_done_holds, clk, rst_n,
        state_reg.phase == pcs_pkg::PH_DONE |=> state_reg.phase == pcs_pkg::PH_DONE,
        "precharged phase left before reset")
    `ASSERT_CLK(a_advance_gives_result, clk, rst_n,
        advance |=> result_valid_reg,
        "tick moved on without a result")
    `ASSERT_ALWAYS(a_gate_needs_contactor, clk, rst_n,
        !result_valid_reg || !result_reg.gate_enable || result_reg.main_contactor,
        "gates enabled with contactor open")
    `ASSERT_ALWAYS(a_no_gate_on_relay, clk, rst_n,
        !result_valid_reg || !(result_reg.gate_enable && result_reg.precharge_relay),
        "gates enabled while precharge relay closed")

endmodule

`default_nettype wire
